// ===== rtl/rtwa_pkg.sv =====
// Package for the radix table walk allocator.
// Result status codes and fixed field widths used by the top-level unit.
// No dependencies.
`default_nettype none

package rtwa_pkg;

    localparam int IDX_W        = 32;
    localparam int SIZE_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int LEAF_NODE_W  = 8;
    localparam int LEAF_ENTRY_W = 7;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_BEYOND    = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/rtwa_table_ram.sv =====
// Single-port-write, single-port-read table RAM with registered read data.
// Holds the radix table entries (valid bit and child node). No package use.
`default_nettype none

module rtwa_table_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15,
    parameter int DATA_W = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/radix_table_walk_alloc_unit.sv =====
// Top level of the radix table walk allocator: request/result channels,
// walk sequencer and node pool. Uses rtwa_pkg and rtwa_table_ram.
// Usage:
//   Request channel (i_in_valid / o_in_stall) carries a slot index and an
//   allocate flag. The unit walks a radix table from root node 0, one level
//   per SLOT_BITS index bits, the level count set by i_cfg_wdata written
//   through i_cfg_we (file size in slots, reset value 1).
//   Result channel (o_out_valid / i_out_stall) returns status, leaf node
//   and leaf entry, one result per request, in request order.
//   Walk: an accepted request passes S_CHECK, then S_READ and S_EVAL for
//   each interior level, then S_FINISH, which loads the result; the level
//   count is 1..MAX_LEVELS. An index beyond the file size or a one-level
//   table goes from S_CHECK straight to S_FINISH. S_READ issues the table
//   RAM read, S_EVAL evaluates the entry and writes any new child link.
//   One request is in flight at a time; the next one is accepted in the
//   cycle after the previous result is loaded into the output register,
//   even while that result is still stalled by the receiver.
//   If the receiver stalls, the result register holds and a finished walk
//   waits until the register frees up.
//   Reset: the table RAM is cleared one entry per cycle, all NODE_COUNT <<
//   SLOT_BITS entries (32768 by default); o_in_stall stays high meanwhile.
//   Configuration writes are taken at any time.
`default_nettype none

module radix_table_walk_alloc_unit #(
    parameter int SLOT_BITS  = 7,
    parameter int NODE_COUNT = 256,
    parameter int MAX_LEVELS = 5
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [rtwa_pkg::SIZE_W-1:0]        i_cfg_wdata,
    // request channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [rtwa_pkg::IDX_W-1:0]         i_slot_index,
    input  wire logic                               i_allocate,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [rtwa_pkg::STATUS_W-1:0]           o_status,
    output logic [rtwa_pkg::LEAF_NODE_W-1:0]        o_leaf_node,
    output logic [rtwa_pkg::LEAF_ENTRY_W-1:0]       o_leaf_entry
);

    import rtwa_pkg::*;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int NF_W    = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W  = NODE_W + SLOT_BITS;
    localparam int DEPTH   = NODE_COUNT * (2 ** SLOT_BITS);
    localparam int DATA_W  = NODE_W + 1;
    localparam int LV_W    = $clog2(MAX_LEVELS + 1);
    localparam int SH_W    = $clog2(MAX_LEVELS * SLOT_BITS + 1);
    localparam int HB_W    = $clog2(SIZE_W);
    localparam int LVF_W   = HB_W + 1;
    localparam int NWIDE_W = (NODE_W > LEAF_NODE_W) ? NODE_W : LEAF_NODE_W;
    localparam int EWIDE_W = (SLOT_BITS > LEAF_ENTRY_W) ? SLOT_BITS : LEAF_ENTRY_W;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_READ   = 6'b001000,
        S_EVAL   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [SIZE_W-1:0]     r_file_size;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_alloc;
    logic [LV_W-1:0]       r_lv, n_lv;
    logic [NODE_W-1:0]     r_node, n_node;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    t_status               r_status, n_status;
    logic [NF_W-1:0]       r_next_free, n_next_free;
    logic [ADDR_W-1:0]     r_clr_cnt;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [LEAF_NODE_W-1:0]  r_out_node;
    logic [LEAF_ENTRY_W-1:0] r_out_entry;

    // table RAM ports
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [DATA_W-1:0]     ram_rdata;

    logic                  in_accept;
    logic                  out_free;
    logic                  beyond;
    logic [SIZE_W-1:0]     size_m1;
    logic [HB_W-1:0]       hb;
    logic [LVF_W-1:0]      lv_full;
    logic [LV_W-1:0]       lv_cfg;
    logic [LV_W-1:0]       lv_dec;
    logic [SH_W-1:0]       shamt;
    logic [IDX_W-1:0]      idx_shift;
    logic [SLOT_BITS-1:0]  lvl_idx;
    logic                  rd_valid;
    logic [NODE_W-1:0]     rd_node;
    logic                  pool_empty;
    logic [NWIDE_W-1:0]    node_wide;
    logic [EWIDE_W-1:0]    entry_wide;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // level count: highest set bit of (size - 1) over SLOT_BITS, plus one
    assign size_m1 = r_file_size - SIZE_W'(1);
    always_comb begin
        hb = '0;
        for (int b = 0; b < SIZE_W; b++) begin
            if (size_m1[b]) begin
                hb = HB_W'(b);
            end
        end
    end
    // quotient by SLOT_BITS as a count of level thresholds passed
    always_comb begin
        lv_full = LVF_W'(1);
        for (int k = 1; k * SLOT_BITS < SIZE_W; k++) begin
            if (hb >= HB_W'(k * SLOT_BITS)) begin
                lv_full = lv_full + LVF_W'(1);
            end
        end
    end
    assign lv_cfg  = (lv_full > LVF_W'(MAX_LEVELS)) ? LV_W'(MAX_LEVELS) : LV_W'(lv_full);
    assign beyond  = (r_file_size == '0) || (r_idx >= r_file_size);

    // index bits for the level being read; bits above the word read as zero
    assign lv_dec    = r_lv - LV_W'(1);
    assign shamt     = SH_W'(lv_dec * SLOT_BITS);
    assign idx_shift = (shamt >= SH_W'(IDX_W)) ? '0 : (r_idx >> shamt);
    assign lvl_idx   = idx_shift[SLOT_BITS-1:0];

    assign rd_valid   = ram_rdata[NODE_W];
    assign rd_node    = ram_rdata[NODE_W-1:0];
    assign pool_empty = (r_next_free >= NF_W'(NODE_COUNT));

    // read is issued only in S_READ; an allocation write lands in S_EVAL,
    // ahead of any later read, so no forwarding is needed
    assign ram_re = (r_state == S_READ);

    always_comb begin
        n_state     = r_state;
        n_lv        = r_lv;
        n_node      = r_node;
        n_addr      = r_addr;
        n_status    = r_status;
        n_next_free = r_next_free;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                if (r_clr_cnt == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_node = '0;
                n_lv   = lv_cfg;
                if (beyond) begin
                    n_status = ST_BEYOND;
                    n_state  = S_FINISH;
                end else begin
                    n_status = ST_FOUND;
                    n_state  = (lv_cfg > LV_W'(1)) ? S_READ : S_FINISH;
                end
            end
            S_READ: begin
                n_lv    = lv_dec;
                n_addr  = {r_node, lvl_idx};
                n_state = S_EVAL;
            end
            S_EVAL: begin
                priority if (rd_valid) begin
                    n_node  = rd_node;
                    n_state = (r_lv > LV_W'(1)) ? S_READ : S_FINISH;
                end else if (!r_alloc) begin
                    n_status = ST_ABSENT;
                    n_state  = S_FINISH;
                end else if (pool_empty) begin
                    n_status = ST_EXHAUSTED;
                    n_state  = S_FINISH;
                end else begin
                    // link a fresh node from the pool
                    ram_we      = 1'b1;
                    ram_wdata   = {1'b1, r_next_free[NODE_W-1:0]};
                    n_node      = r_next_free[NODE_W-1:0];
                    n_next_free = r_next_free + NF_W'(1);
                    n_state     = (r_lv > LV_W'(1)) ? S_READ : S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_next_free <= NF_W'(1);
            r_file_size <= SIZE_W'(1);
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                r_file_size <= i_cfg_wdata;
            end
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        r_lv     <= n_lv;
        r_node   <= n_node;
        r_addr   <= n_addr;
        r_status <= n_status;
        if (in_accept) begin
            r_idx   <= i_slot_index;
            r_alloc <= i_allocate;
        end
    end

    // result register
    assign node_wide  = NWIDE_W'(r_node);
    assign entry_wide = EWIDE_W'(r_idx[SLOT_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && out_free) begin
            r_out_status <= r_status;
            r_out_node   <= (r_status == ST_FOUND) ? node_wide[LEAF_NODE_W-1:0] : '0;
            r_out_entry  <= entry_wide[LEAF_ENTRY_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_leaf_node  = r_out_node;
    assign o_leaf_entry = r_out_entry;

    rtwa_table_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (n_addr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
